### hw/rtl/tpc_pkg.sv
package tpc_pkg;

   // default sizes
   localparam int NODE_POOL_DEF  = 4096;
   localparam int ALPHABET_DEF   = 26;
   localparam int COUNT_BITS_DEF = 16;

   // fixed field widths
   localparam int LETTER_W    = 5;
   localparam int OUT_COUNT_W = 16;

   // depth of the command and result queues
   localparam int QUEUE_DEPTH = 2;

   // input mode codes
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_QUERY  = 1'b1;

   // result status codes
   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_POOL_FULL = 1'b1;

   // classified letter, as queued between front and back
   typedef struct packed {
      logic                query;
      logic [LETTER_W-1:0] letter;
      logic                bad;
      logic                last;
   } cmd_type;

   // one result item
   typedef struct packed {
      logic [OUT_COUNT_W-1:0] prefix_count;
      logic                   status;
   } rsp_type;

   // back-end control seen by the front end and the top level
   typedef struct packed {
      logic cmd_pop;
      logic clearing;
   } back_ctl_type;

   // back-end sequencer
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_STEP,
      ST_LREAD,
      ST_LAST
   } state_type;

endpackage

### hw/rtl/tpc_fifo.sv
module tpc_fifo #(
   parameter int WIDTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] dout
);
   import tpc_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign dout    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      cnt_in = cnt_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

### hw/rtl/tpc_front.sv
module tpc_front #(
   parameter int ALPHABET = tpc_pkg::ALPHABET_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic                          req_mode,
   input  logic [tpc_pkg::LETTER_W-1:0]  req_letter,
   input  logic                          req_last,
   input  tpc_pkg::back_ctl_type         ctl,
   output logic                          cmd_valid,
   output tpc_pkg::cmd_type              cmd
);
   import tpc_pkg::*;

   cmd_type cmd_new;
   cmd_type cmd_head;
   logic    q_full;
   logic    q_empty;

   // classify: decode the mode and flag letters outside the alphabet
   always_comb begin
      cmd_new.query  = (req_mode == MODE_QUERY);
      cmd_new.letter = req_letter;
      cmd_new.bad    = (32'(req_letter) >= 32'(ALPHABET));
      cmd_new.last   = req_last;
   end

   // no items taken while the stores are being cleared
   assign req_full  = q_full || ctl.clearing;
   assign cmd_valid = !q_empty;
   assign cmd       = cmd_head;

   tpc_fifo #(
      .WIDTH ($bits(cmd_type))
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (req_push && !ctl.clearing),
      .din   (cmd_new),
      .full  (q_full),
      .pop   (ctl.cmd_pop),
      .empty (q_empty),
      .dout  (cmd_head)
   );

endmodule

### hw/rtl/tpc_back.sv
module tpc_back #(
   parameter int NODE_POOL  = tpc_pkg::NODE_POOL_DEF,
   parameter int ALPHABET   = tpc_pkg::ALPHABET_DEF,
   parameter int COUNT_BITS = tpc_pkg::COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   input  tpc_pkg::cmd_type      cmd,
   output tpc_pkg::back_ctl_type ctl,
   input  logic                  rsp_full,
   output logic                  rsp_push,
   output tpc_pkg::rsp_type      rsp_item
);
   import tpc_pkg::*;

   localparam int TOTAL  = NODE_POOL * ALPHABET;
   localparam int ADDR_W = $clog2(TOTAL);
   localparam int NODE_W = $clog2(NODE_POOL);
   localparam int NF_W   = $clog2(NODE_POOL + 1);
   localparam int WIDE_W = (COUNT_BITS > OUT_COUNT_W) ? COUNT_BITS : OUT_COUNT_W;

   // child table and per-node counts
   logic [NODE_W-1:0]     child_mem [TOTAL];
   logic [COUNT_BITS-1:0] cnt_mem   [NODE_POOL];

   state_type             state_ff, state_in;
   logic [ADDR_W-1:0]     clr_ff, clr_in;
   logic [NODE_W-1:0]     cursor_ff, cursor_in;
   logic [NF_W-1:0]       next_free_ff, next_free_in;
   logic                  missed_ff, missed_in;
   logic                  over_ff, over_in;
   logic                  query_ff, query_in;
   logic                  last_ff, last_in;
   logic [ADDR_W-1:0]     slot_ff, slot_in;
   logic [NODE_W-1:0]     child_rd_ff;
   logic [COUNT_BITS-1:0] cnt_rd_ff;

   logic                  cr_en;
   logic [ADDR_W-1:0]     cr_addr;
   logic                  cw_en;
   logic [ADDR_W-1:0]     cw_addr;
   logic [NODE_W-1:0]     cw_data;
   logic                  nr_en;
   logic [NODE_W-1:0]     nr_addr;
   logic                  nw_en;
   logic [NODE_W-1:0]     nw_addr;
   logic [COUNT_BITS-1:0] nw_data;

   logic [ADDR_W-1:0]     head_slot;
   logic [COUNT_BITS-1:0] cnt_bump;
   logic [WIDE_W-1:0]     cnt_wide;
   logic [OUT_COUNT_W-1:0] cnt_sat;
   logic                  child_absent;

   // slot of the queued letter under the current node
   assign head_slot = ADDR_W'(cursor_ff) * ADDR_W'(ALPHABET) + ADDR_W'(cmd.letter);

   // saturating increment and output clamp
   assign cnt_bump = (&cnt_rd_ff) ? cnt_rd_ff : cnt_rd_ff + 1'b1;
   assign cnt_wide = WIDE_W'(cnt_rd_ff);
   assign cnt_sat  = (cnt_wide > WIDE_W'({OUT_COUNT_W{1'b1}})) ?
                     {OUT_COUNT_W{1'b1}} : cnt_wide[OUT_COUNT_W-1:0];
   assign child_absent = (child_rd_ff == '0);

   // sequencer: next state, memory ports and result
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cursor_in    = cursor_ff;
      next_free_in = next_free_ff;
      missed_in    = missed_ff;
      over_in      = over_ff;
      query_in     = query_ff;
      last_in      = last_ff;
      slot_in      = slot_ff;
      cr_en        = 1'b0;
      cr_addr      = head_slot;
      cw_en        = 1'b0;
      cw_addr      = slot_ff;
      cw_data      = next_free_ff[NODE_W-1:0];
      nr_en        = 1'b0;
      nr_addr      = cursor_ff;
      nw_en        = 1'b0;
      nw_addr      = cursor_ff;
      nw_data      = cnt_bump;
      ctl.cmd_pop  = 1'b0;
      ctl.clearing = (state_ff == ST_CLEAR);
      rsp_push     = 1'b0;
      rsp_item.prefix_count = '0;
      rsp_item.status       = STATUS_OK;

      unique case (state_ff)
         // zero both stores, one child entry per cycle
         ST_CLEAR: begin
            cw_en   = 1'b1;
            cw_addr = clr_ff;
            cw_data = '0;
            nw_en   = (clr_ff < ADDR_W'(NODE_POOL));
            nw_addr = clr_ff[NODE_W-1:0];
            nw_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(TOTAL - 1)) begin
               state_in = ST_IDLE;
            end
         end

         // take a letter; live letters start the child and count reads
         ST_IDLE: begin
            if (cmd_valid) begin
               ctl.cmd_pop = 1'b1;
               query_in    = cmd.query;
               last_in     = cmd.last;
               slot_in     = head_slot;
               if (missed_ff || cmd.bad) begin
                  missed_in = 1'b1;
                  if (cmd.last) begin
                     state_in = ST_LAST;
                  end
               end else begin
                  cr_en    = 1'b1;
                  nr_en    = 1'b1;
                  state_in = ST_STEP;
               end
            end
         end

         // walk or extend the path, bumping the current node's count on insert
         ST_STEP: begin
            if (query_ff) begin
               if (child_absent) begin
                  missed_in = 1'b1;
               end else begin
                  cursor_in = child_rd_ff;
               end
            end else begin
               nw_en = 1'b1;
               if (!child_absent) begin
                  cursor_in = child_rd_ff;
               end else if (next_free_ff < NF_W'(NODE_POOL)) begin
                  cw_en        = 1'b1;
                  cursor_in    = next_free_ff[NODE_W-1:0];
                  next_free_in = next_free_ff + 1'b1;
               end else begin
                  over_in   = 1'b1;
                  missed_in = 1'b1;
               end
            end
            state_in = last_ff ? ST_LREAD : ST_IDLE;
         end

         // fetch the end node's count
         ST_LREAD: begin
            nr_en    = 1'b1;
            state_in = ST_LAST;
         end

         // deliver the result, bump the end node on insert, back to root
         ST_LAST: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               if (query_ff) begin
                  rsp_item.prefix_count = missed_ff ? '0 : cnt_sat;
               end else begin
                  rsp_item.status = over_ff ? STATUS_POOL_FULL : STATUS_OK;
                  nw_en           = !missed_ff;
               end
               cursor_in = '0;
               missed_in = 1'b0;
               over_in   = 1'b0;
               state_in  = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cursor_ff    <= '0;
         next_free_ff <= NF_W'(1);
         missed_ff    <= 1'b0;
         over_ff      <= 1'b0;
         query_ff     <= 1'b0;
         last_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cursor_ff    <= cursor_in;
         next_free_ff <= next_free_in;
         missed_ff    <= missed_in;
         over_ff      <= over_in;
         query_ff     <= query_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   // child table: one write, one registered read
   always_ff @(posedge clock) begin
      if (cw_en) begin
         child_mem[cw_addr] <= cw_data;
      end
      if (cr_en) begin
         child_rd_ff <= child_mem[cr_addr];
      end
   end

   // node counts: one write, one registered read
   always_ff @(posedge clock) begin
      if (nw_en) begin
         cnt_mem[nw_addr] <= nw_data;
      end
      if (nr_en) begin
         cnt_rd_ff <= cnt_mem[nr_addr];
      end
   end

endmodule

### hw/rtl/trie_prefix_counter_unit.sv
// Prefix-counting trie. Words arrive one letter per item (req_mode 0 inserts,
// 1 queries; req_last marks the final letter); one result item comes out per
// final letter: the queried prefix's word count, or for an insert a status
// telling whether the node pool ran out. After reset the unit zeroes its child
// table and node counts (NODE_POOL*ALPHABET child entries, 106,496 at the
// defaults), holding req_full high meanwhile. Afterwards the back end handles
// one letter at a time: a non-final letter takes a child-table read, then the
// count and child update; a final letter adds an end-node count read and the
// result with count write-back; a letter after the word has left the trie skips
// the reads. A final letter also waits while the result queue is full. These
// steps come from the registered reads of the child table and count memory,
// which every letter still in the trie needs before it can update them.
// Two-entry queues sit on both the input and result side.
module trie_prefix_counter_unit #(
   parameter int NODE_POOL  = tpc_pkg::NODE_POOL_DEF,
   parameter int ALPHABET   = tpc_pkg::ALPHABET_DEF,
   parameter int COUNT_BITS = tpc_pkg::COUNT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic                            req_mode,
   input  logic [tpc_pkg::LETTER_W-1:0]    req_letter,
   input  logic                            req_last,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [tpc_pkg::OUT_COUNT_W-1:0] rsp_prefix_count,
   output logic                            rsp_status
);
   import tpc_pkg::*;

   back_ctl_type ctl;
   cmd_type      cmd;
   logic         cmd_valid;
   logic         rsp_q_full;
   logic         rsp_q_push;
   rsp_type      rsp_new;
   rsp_type      rsp_head;

   tpc_front #(
      .ALPHABET (ALPHABET)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_mode   (req_mode),
      .req_letter (req_letter),
      .req_last   (req_last),
      .ctl        (ctl),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd)
   );

   tpc_back #(
      .NODE_POOL  (NODE_POOL),
      .ALPHABET   (ALPHABET),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .ctl       (ctl),
      .rsp_full  (rsp_q_full),
      .rsp_push  (rsp_q_push),
      .rsp_item  (rsp_new)
   );

   // result queue
   tpc_fifo #(
      .WIDTH ($bits(rsp_type))
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_q_push),
      .din   (rsp_new),
      .full  (rsp_q_full),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .dout  (rsp_head)
   );

   assign rsp_prefix_count = rsp_head.prefix_count;
   assign rsp_status       = rsp_head.status;

`ifndef SYNTH
   // back end never drops a result into a full queue
   assert property (@(posedge clock) disable iff (reset) rsp_q_push |-> !rsp_q_full)
      else $error("result pushed into full queue");

   // back end only takes letters that are queued
   assert property (@(posedge clock) disable iff (reset) ctl.cmd_pop |-> cmd_valid)
      else $error("command popped from empty queue");

   // input closed during the clearing pass
   assert property (@(posedge clock) disable iff (reset) ctl.clearing |-> req_full)
      else $error("input open while clearing");

   // a pushed result is visible next cycle
   assert property (@(posedge clock) disable iff (reset) rsp_q_push |=> !rsp_empty)
      else $error("pushed result not visible");
`endif

endmodule
